// ===== sv/cgc_pkg.sv =====
// Package with shared types and constants for the complement graph components block.
`default_nettype none
package cgc_pkg;
	localparam int unsigned MaxVerticesDefault = 64;
	localparam logic [6:0] VertexCountReset = 7'd64;

	// Input item: edge add or report request.
	typedef struct packed {
		logic       operation;
		logic [6:0] first_vertex;
		logic [6:0] second_vertex;
	} cgc_in_t;

	// Result item: one component size of a report.
	typedef struct packed {
		logic [6:0] component_size;
		logic [5:0] component_rank;
		logic [6:0] component_count;
		logic       last;
	} cgc_out_t;

	localparam logic OpAddEdge = 1'b0;
	localparam logic OpReport  = 1'b1;
endpackage
`default_nettype wire

// ===== sv/cgc_matrix.sv =====
// Adjacency row memory with one write port and one registered read port.
`default_nettype none
module cgc_matrix #(
	parameter int unsigned MAX_VERTICES = 64,
	localparam int unsigned AW = $clog2(MAX_VERTICES)
) (
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic [AW-1:0]           wr_addr,
	input  wire logic [MAX_VERTICES-1:0] wr_data,
	input  wire logic [AW-1:0]           rd_addr,
	output logic      [MAX_VERTICES-1:0] rd_data
);
	logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];

	// One write and one registered read each cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

// ===== sv/cgc_sizes.sv =====
// Size list memory with one write port and one registered read port.
`default_nettype none
module cgc_sizes #(
	parameter int unsigned MAX_VERTICES = 64,
	localparam int unsigned AW = $clog2(MAX_VERTICES),
	localparam int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [CW-1:0] wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [CW-1:0] rd_data
);
	logic [CW-1:0] mem [MAX_VERTICES];

	// One write and one registered read each cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

// ===== sv/complement_graph_components_top.sv =====
// Top level of the complement graph components block.
// Edge add: no result; for a valid edge in_stall then stays high through ST_EDGE2 and ST_WAIT.
// Report: per vertex, pop, row read and claim of unvisited non-neighbours; then an insertion
// sort of the sizes, one result per size held through receiver stalls, then a clearing
// sweep of the matrix over its MAX_VERTICES rows.
// Reset clears control state and sets vertex_count to 64; the matrix is swept clear after reset.
`default_nettype none
module complement_graph_components_top #(
	parameter int unsigned MAX_VERTICES = cgc_pkg::MaxVerticesDefault
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire cgc_pkg::cgc_in_t in_data,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output cgc_pkg::cgc_out_t    out_data,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [6:0]      cfg_data
);
	import cgc_pkg::*;

	localparam int unsigned AW = $clog2(MAX_VERTICES);
	localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
	localparam int unsigned NW = (CW > 7) ? CW : 7;

	typedef enum logic [11:0] {
		ST_CLEAR  = 12'b000000000001,
		ST_IDLE   = 12'b000000000010,
		ST_EDGE2  = 12'b000000000100,
		ST_START  = 12'b000000001000,
		ST_POP    = 12'b000000010000,
		ST_WAIT   = 12'b000000100000,
		ST_CLAIM  = 12'b000001000000,
		ST_SRTRD  = 12'b000010000000,
		ST_SRTCMP = 12'b000100000000,
		ST_OUTRD  = 12'b001000000000,
		ST_OUTW   = 12'b010000000000,
		ST_OUT    = 12'b100000000000
	} state_t;

	state_t                  state_q;
	logic [6:0]              vcount_q;
	logic [MAX_VERTICES-1:0] unv_q;
	logic [MAX_VERTICES-1:0] queue_q;   // vertices claimed but not yet popped
	logic [CW-1:0]           size_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           cur_q;
	logic [AW-1:0]           addr_q;
	logic [AW-1:0]           ea_q;
	logic [AW-1:0]           eb_q;
	logic [CW-1:0]           i_q;
	logic [CW-1:0]           j_q;
	logic [CW-1:0]           key_q;
	logic                    sort_ph_q;

	logic                    m_we;
	logic [AW-1:0]           m_wa;
	logic [MAX_VERTICES-1:0] m_wd;
	logic [AW-1:0]           m_ra;
	logic [MAX_VERTICES-1:0] m_rd;
	logic                    s_we;
	logic [AW-1:0]           s_wa;
	logic [CW-1:0]           s_wd;
	logic [AW-1:0]           s_ra;
	logic [CW-1:0]           s_rd;

	cgc_matrix #(.MAX_VERTICES(MAX_VERTICES)) u_matrix (
		.clk(clk), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
		.rd_addr(m_ra), .rd_data(m_rd)
	);
	cgc_sizes #(.MAX_VERTICES(MAX_VERTICES)) u_sizes (
		.clk(clk), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
		.rd_addr(s_ra), .rd_data(s_rd)
	);

	// Effective vertex count, saturated at the matrix size.
	logic [NW-1:0] n_eff;
	always_comb begin
		if (NW'(vcount_q) > NW'(MAX_VERTICES)) begin
			n_eff = NW'(MAX_VERTICES);
		end else begin
			n_eff = NW'(vcount_q);
		end
	end

	// Lowest set bit finders for the unvisited mask and the pending queue.
	function automatic logic [AW-1:0] low_bit(input logic [MAX_VERTICES-1:0] w);
		logic [AW-1:0] r;
		r = '0;
		for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
			if (w[k]) begin
				r = AW'(k);
			end
		end
		return r;
	endfunction

	logic [MAX_VERTICES-1:0] claim;
	logic [MAX_VERTICES-1:0] unv_all;
	logic [NW-1:0]           fv, sv;
	logic                    edge_ok;
	always_comb begin
		claim = unv_q & ~m_rd;
		for (int k = 0; k < MAX_VERTICES; k++) begin
			unv_all[k] = (NW'(k) < n_eff);
		end
		fv = NW'(in_data.first_vertex);
		sv = NW'(in_data.second_vertex);
		edge_ok = (fv != '0) && (sv != '0) && (fv <= n_eff) && (sv <= n_eff);
	end

	// Matrix port control: read-modify-write for edges, sweep for clearing, row reads for BFS.
	logic accept;
	assign accept = in_valid && !in_stall;
	always_comb begin
		m_we = 1'b0;
		m_wa = addr_q;
		m_wd = '0;
		m_ra = cur_q;
		case (state_q)
			ST_CLEAR: begin
				m_we = 1'b1;
			end
			ST_IDLE: begin
				m_ra = AW'(fv - NW'(1));
			end
			ST_EDGE2: begin
				m_we = 1'b1;
				m_wa = ea_q;
				m_wd = m_rd | (MAX_VERTICES'(1) << eb_q);
				m_ra = eb_q;
			end
			ST_WAIT: begin
				// Second half of an edge: write row b with bit a.
				if (sort_ph_q) begin
					m_we = 1'b1;
					m_wa = eb_q;
					m_wd = m_rd | (MAX_VERTICES'(1) << ea_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Size memory port control.
	always_comb begin
		s_we = 1'b0;
		s_wa = count_q[AW-1:0];
		s_wd = size_q;
		s_ra = i_q[AW-1:0];
		case (state_q)
			ST_POP: begin
				s_we = (queue_q == '0);
			end
			ST_SRTRD: begin
				// Phase 0 reads the key at i; phase 1 reads the element at j-1.
				if (sort_ph_q) begin
					s_ra = AW'(j_q - CW'(1));
				end
			end
			ST_SRTCMP: begin
				if (j_q != '0 && sort_ph_q && s_rd > key_q) begin
					s_we = 1'b1;
					s_wa = j_q[AW-1:0];
					s_wd = s_rd;
				end else if (sort_ph_q) begin
					s_we = 1'b1;
					s_wa = j_q[AW-1:0];
					s_wd = key_q;
				end
			end
			ST_OUTRD: begin
				s_ra = i_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			vcount_q  <= VertexCountReset;
			addr_q    <= '0;
			out_valid <= 1'b0;
			sort_ph_q <= 1'b0;
			count_q   <= '0;
			unv_q     <= '0;
			queue_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(MAX_VERTICES - 1)) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_data.operation == OpReport) begin
							unv_q   <= unv_all;
							count_q <= '0;
							state_q <= ST_START;
						end else if (edge_ok) begin
							ea_q    <= AW'(fv - NW'(1));
							eb_q    <= AW'(sv - NW'(1));
							state_q <= ST_EDGE2;
						end
					end
				end
				ST_EDGE2: begin
					// Row a written; row b is being read.
					sort_ph_q <= 1'b1;
					state_q   <= ST_WAIT;
				end
				ST_START: begin
					if (unv_q == '0) begin
						i_q     <= CW'(1);
						state_q <= ST_SRTRD;
					end else begin
						queue_q <= MAX_VERTICES'(1) << low_bit(unv_q);
						unv_q   <= unv_q & ~(MAX_VERTICES'(1) << low_bit(unv_q));
						size_q  <= CW'(1);
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					if (queue_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_START;
					end else begin
						cur_q   <= low_bit(queue_q);
						queue_q <= queue_q & ~(MAX_VERTICES'(1) << low_bit(queue_q));
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (sort_ph_q) begin
						sort_ph_q <= 1'b0;
						state_q   <= ST_IDLE;
					end else begin
						state_q <= ST_CLAIM;
					end
				end
				ST_CLAIM: begin
					unv_q   <= unv_q & ~claim;
					queue_q <= queue_q | claim;
					size_q  <= size_q + CW'($countones(claim));
					state_q <= ST_POP;
				end
				ST_SRTRD: begin
					// Phase 0 fetches key i; phase 1 reads element j-1.
					if (i_q >= count_q) begin
						i_q     <= '0;
						state_q <= ST_OUTRD;
					end else if (!sort_ph_q) begin
						j_q     <= i_q;
						state_q <= ST_SRTCMP;
					end else begin
						state_q <= ST_SRTCMP;
					end
				end
				ST_SRTCMP: begin
					if (!sort_ph_q) begin
						key_q     <= s_rd;
						sort_ph_q <= 1'b1;
						state_q   <= ST_SRTRD;
					end else if (j_q != '0 && s_rd > key_q) begin
						j_q     <= j_q - CW'(1);
						state_q <= ST_SRTRD;
					end else begin
						sort_ph_q <= 1'b0;
						i_q       <= i_q + CW'(1);
						state_q   <= ST_SRTRD;
					end
				end
				ST_OUTRD: begin
					if (i_q >= count_q) begin
						addr_q  <= '0;
						state_q <= ST_CLEAR;
					end else begin
						state_q <= ST_OUTW;
					end
				end
				ST_OUTW: begin
					out_data.component_size  <= 7'(s_rd);
					out_data.component_rank  <= 6'(i_q);
					out_data.component_count <= 7'(count_q);
					out_data.last            <= (i_q + CW'(1) == count_q);
					out_valid                <= 1'b1;
					state_q                  <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						i_q       <= i_q + CW'(1);
						state_q   <= ST_OUTRD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
